// ===== rtl/ftsc_pkg.sv =====
// package with constants, codes and controller/datapath types of the flow to step count interpolator
`default_nettype none

package ftsc_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int CFG_W   = 6;
  localparam int SLOT_W  = 5;
  localparam int VAL_W   = 16;
  localparam int DIFF_W  = VAL_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int MAG_W   = 2 * VAL_W;
  localparam int DCNT_W  = $clog2(MAG_W);
  localparam int RES_W   = PROD_W + 1;

  localparam logic [CFG_W-1:0] ENTRIES_RESET = 6'd31;
  localparam logic [VAL_W-1:0] FLOW_DEFAULT  = 16'd100;
  localparam logic [VAL_W-1:0] COUNT_MIN     = 16'd1;
  localparam logic [VAL_W-1:0] COUNT_MAX     = 16'hFFFF;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    MODE_BELOW,
    MODE_INSIDE,
    MODE_EXTRAP
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_RD_A,
    ST_RD_B,
    ST_LD_B,
    ST_OPS,
    ST_MUL,
    ST_ABS,
    ST_DIV,
    ST_FIX,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic write_entry;
    logic start;
    logic idx_inc;
    logic set_pair;
    logic rd_a;
    logic rd_b;
    logic cap_a;
    logic cap_b;
    logic ops;
    logic mul;
    logic abs_init;
    logic div_step;
    logic fix;
    logic fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic idx_end;
    logic q_gt;
    logic div_last;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/ftsc_if.sv =====
// channel interfaces for item, result and configuration beats
`default_nettype none

interface ftsc_in_if;
  import ftsc_pkg::*;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [SLOT_W-1:0]  entry_slot;
  logic [VAL_W-1:0]   entry_flow;
  logic [VAL_W-1:0]   entry_count;
  logic [VAL_W-1:0]   query_flow;

  modport source (output valid, cmd, entry_slot, entry_flow, entry_count, query_flow,
                  input ready);
  modport sink   (input valid, cmd, entry_slot, entry_flow, entry_count, query_flow,
                  output ready);
endinterface

interface ftsc_out_if;
  import ftsc_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] step_count;
  logic             saturated;

  modport source (output valid, step_count, saturated, input ready);
  modport sink   (input valid, step_count, saturated, output ready);
endinterface

interface ftsc_cfg_if;
  import ftsc_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/ftsc_ctrl.sv =====
// controller state machine sequencing search, fetch, multiply, divide and output
`default_nettype none

module ftsc_ctrl
  import ftsc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_cmd_i,
  output      logic       in_ready_o,
  input  wire dp_status_t status_i,
  output      ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_cmd_i == CMD_QUERY)) begin
          state_d = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        if (status_i.idx_end) begin
          state_d = ST_RD_A;
        end else begin
          state_d = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        if (status_i.q_gt) begin
          state_d = ST_SRCH_RD;
        end else begin
          state_d = ST_RD_A;
        end
      end
      ST_RD_A: state_d = ST_RD_B;
      ST_RD_B: state_d = ST_LD_B;
      ST_LD_B: state_d = ST_OPS;
      ST_OPS:  state_d = ST_MUL;
      ST_MUL:  state_d = ST_ABS;
      ST_ABS:  state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.div_last) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: state_d = ST_FIN;
      ST_FIN: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.write_entry = in_valid_i && (in_cmd_i == CMD_WRITE);
        cmd_o.start       = in_valid_i && (in_cmd_i == CMD_QUERY);
      end
      ST_SRCH_RD: begin
        cmd_o.set_pair = status_i.idx_end;
      end
      ST_SRCH_CMP: begin
        cmd_o.idx_inc  = status_i.q_gt;
        cmd_o.set_pair = !status_i.q_gt;
      end
      ST_RD_A: cmd_o.rd_a = 1'b1;
      ST_RD_B: begin
        cmd_o.rd_b  = 1'b1;
        cmd_o.cap_a = 1'b1;
      end
      ST_LD_B:  cmd_o.cap_b    = 1'b1;
      ST_OPS:   cmd_o.ops      = 1'b1;
      ST_MUL:   cmd_o.mul      = 1'b1;
      ST_ABS:   cmd_o.abs_init = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_FIX:   cmd_o.fix      = 1'b1;
      ST_FIN:   cmd_o.fin      = !status_i.out_busy;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/ftsc_datapath.sv =====
// datapath with calibration memory, search index, multiplier, serial divider and output register
`default_nettype none

module ftsc_datapath
  import ftsc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctrl_cmd_t         cmd_i,
  output      dp_status_t        status_o,
  input  wire logic [SLOT_W-1:0] entry_slot_i,
  input  wire logic [VAL_W-1:0]  entry_flow_i,
  input  wire logic [VAL_W-1:0]  entry_count_i,
  input  wire logic [VAL_W-1:0]  query_flow_i,
  input  wire logic              cfg_valid_i,
  input  wire logic [CFG_W-1:0]  cfg_data_i,
  input  wire logic              out_ready_i,
  output      logic              out_valid_o,
  output      logic [VAL_W-1:0]  step_count_o,
  output      logic              saturated_o
);

  logic [2*VAL_W-1:0] tbl_mem [TABLE_DEPTH];
  logic [2*VAL_W-1:0] rdata_q;
  logic [IDX_W-1:0]   raddr;

  logic [CFG_W-1:0]   entries_q;
  logic [CNT_W-1:0]   n_q, n_clamp;
  logic [CNT_W-1:0]   idx_q;
  logic [VAL_W-1:0]   q_q;
  mode_e              mode_q;
  logic [IDX_W-1:0]   ia_q, ib_q;
  logic [VAL_W-1:0]   af_q, ac_q, bf_q, bc_q;
  logic [VAL_W-1:0]   base_q;
  logic [DIFF_W-1:0]  dc_q, dx_q, df_q;
  logic signed [PROD_W-1:0] prod_s;
  logic [PROD_W-1:0]  prod_q;
  logic [PROD_W-1:0]  prod_neg, df_neg_full;
  logic [DIFF_W-1:0]  df_neg;
  logic [MAG_W-1:0]   num_q;
  logic [VAL_W-1:0]   den_q;
  logic [VAL_W-1:0]   rem_q;
  logic               neg_q, zdf_q;
  logic [DCNT_W-1:0]  dcnt_q;
  logic [DIFF_W-1:0]  shifted;
  logic               ge;
  logic [MAG_W:0]     mag;
  logic [PROD_W-1:0]  qs_q;
  logic [RES_W-1:0]   res;
  logic               out_valid_q;
  logic [VAL_W-1:0]   step_q;
  logic               sat_q;

  // calibration memory
  always_comb begin
    if (cmd_i.rd_a) begin
      raddr = ia_q;
    end else if (cmd_i.rd_b) begin
      raddr = ib_q;
    end else begin
      raddr = idx_q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_entry && (32'(entry_slot_i) < 32'(TABLE_DEPTH))) begin
      tbl_mem[IDX_W'(entry_slot_i)] <= {entry_flow_i, entry_count_i};
    end
    rdata_q <= tbl_mem[raddr];
  end

  // configuration and output control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q   <= ENTRIES_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        entries_q <= cfg_data_i;
      end
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    if (32'(entries_q) < 32'd2) begin
      n_clamp = CNT_W'(2);
    end else if (32'(entries_q) > 32'(TABLE_DEPTH)) begin
      n_clamp = CNT_W'(TABLE_DEPTH);
    end else begin
      n_clamp = CNT_W'(entries_q);
    end
  end

  // search and pair selection
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      n_q   <= n_clamp;
      idx_q <= '0;
      q_q   <= (query_flow_i == '0) ? FLOW_DEFAULT : query_flow_i;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + CNT_W'(1);
    end
    if (cmd_i.set_pair) begin
      if (idx_q == n_q) begin
        mode_q <= MODE_EXTRAP;
        ia_q   <= IDX_W'(n_q - CNT_W'(2));
        ib_q   <= IDX_W'(n_q - CNT_W'(1));
      end else if (idx_q == '0) begin
        mode_q <= MODE_BELOW;
        ia_q   <= '0;
        ib_q   <= '0;
      end else begin
        mode_q <= MODE_INSIDE;
        ia_q   <= IDX_W'(idx_q - CNT_W'(1));
        ib_q   <= idx_q[IDX_W-1:0];
      end
    end
    if (cmd_i.cap_a) begin
      {af_q, ac_q} <= rdata_q;
    end
    if (cmd_i.cap_b) begin
      {bf_q, bc_q} <= rdata_q;
    end
  end

  // line operands
  always_ff @(posedge clk_i) begin
    if (cmd_i.ops) begin
      case (mode_q)
        MODE_EXTRAP: begin
          base_q <= bc_q;
          dc_q   <= {1'b0, bc_q} - {1'b0, ac_q};
          dx_q   <= {1'b0, q_q} - {1'b0, bf_q};
          df_q   <= {1'b0, bf_q} - {1'b0, af_q};
        end
        MODE_INSIDE: begin
          base_q <= ac_q;
          dc_q   <= {1'b0, bc_q} - {1'b0, ac_q};
          dx_q   <= {1'b0, q_q} - {1'b0, af_q};
          df_q   <= {1'b0, bf_q} - {1'b0, af_q};
        end
        default: begin
          base_q <= (bf_q == '0) ? bc_q : '0;
          dc_q   <= {1'b0, bc_q};
          dx_q   <= {1'b0, q_q};
          df_q   <= {1'b0, bf_q};
        end
      endcase
    end
  end

  // multiply, then sign and magnitude for the divider
  assign prod_s      = $signed(dc_q) * $signed(dx_q);
  assign prod_neg    = ~prod_q + PROD_W'(1);
  assign df_neg      = ~df_q + DIFF_W'(1);
  assign df_neg_full = PROD_W'(df_neg);

  // restoring divide, one quotient bit a cycle
  assign shifted = {rem_q, num_q[MAG_W-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign mag     = {1'b0, num_q} + (MAG_W+1)'(rem_q != '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= prod_s;
    end
    if (cmd_i.abs_init) begin
      num_q  <= prod_q[PROD_W-1] ? prod_neg[MAG_W-1:0] : prod_q[MAG_W-1:0];
      den_q  <= df_q[DIFF_W-1] ? df_neg_full[VAL_W-1:0] : df_q[VAL_W-1:0];
      neg_q  <= prod_q[PROD_W-1] ^ df_q[DIFF_W-1];
      zdf_q  <= (df_q == '0);
      rem_q  <= '0;
      dcnt_q <= DCNT_W'(MAG_W - 1);
    end else if (cmd_i.div_step) begin
      num_q  <= {num_q[MAG_W-2:0], ge};
      rem_q  <= ge ? VAL_W'(shifted - {1'b0, den_q}) : shifted[VAL_W-1:0];
      dcnt_q <= dcnt_q - DCNT_W'(1);
    end
    if (cmd_i.fix) begin
      if (zdf_q) begin
        qs_q <= '0;
      end else if (neg_q) begin
        qs_q <= PROD_W'(0) - {1'b0, mag};
      end else begin
        qs_q <= PROD_W'(num_q);
      end
    end
  end

  // floor result, clamp and saturate
  assign res = {{(RES_W-VAL_W){1'b0}}, base_q} + {qs_q[PROD_W-1], qs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      if (res[RES_W-1] || (res == '0)) begin
        step_q <= COUNT_MIN;
        sat_q  <= 1'b0;
      end else if (|res[RES_W-2:VAL_W]) begin
        step_q <= COUNT_MAX;
        sat_q  <= 1'b1;
      end else begin
        step_q <= res[VAL_W-1:0];
        sat_q  <= 1'b0;
      end
    end
  end

  assign status_o.idx_end  = (idx_q == n_q);
  assign status_o.q_gt     = q_q > rdata_q[2*VAL_W-1:VAL_W];
  assign status_o.div_last = (dcnt_q == '0);
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign step_count_o = step_q;
  assign saturated_o  = sat_q;

endmodule

`default_nettype wire

// ===== rtl/flow_to_step_count_interpolator.sv =====
// top level of the flow to step count interpolator
`default_nettype none

// Calibration table of (flow, step count) pairs turned into a pump step count.
// A write beat (cmd 0) stores one entry. A query beat (cmd 1) searches the
// table one entry at a time (memory read, then compare), fetches the
// bracketing pair, multiplies once and runs a restoring divider, then loads
// the result into the output register once any earlier result has been taken.
// The output register is held until taken and the next beat is accepted as
// soon as the result has been loaded.
// Configuration beats are always accepted; the table needs no clearing.
module flow_to_step_count_interpolator
  import ftsc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ftsc_in_if.sink    in_i,
  ftsc_out_if.source out_o,
  ftsc_cfg_if.sink   cfg_i
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  assign cfg_i.ready = 1'b1;

  ftsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  ftsc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .status_o      (dp_status),
    .entry_slot_i  (in_i.entry_slot),
    .entry_flow_i  (in_i.entry_flow),
    .entry_count_i (in_i.entry_count),
    .query_flow_i  (in_i.query_flow),
    .cfg_valid_i   (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .step_count_o  (out_o.step_count),
    .saturated_o   (out_o.saturated)
  );

endmodule

`default_nettype wire

// ===== rtl/ftsc_checker.sv =====
// port level checker of the flow to step count interpolator and its bind
`default_nettype none

module ftsc_checker
  import ftsc_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_i,
  input wire logic             in_cmd_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [VAL_W-1:0] step_count_i,
  input wire logic             saturated_i
);

  // a result is never below one
  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (step_count_i != '0))
    else $error("step count of zero on a result beat");

  // saturation only comes with the clipped maximum
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && saturated_i) |-> (step_count_i == COUNT_MAX))
    else $error("saturated flag without maximum step count");

  // a query occupies the block for at least the next cycle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_cmd_i == CMD_QUERY)) |=> !in_ready_i)
    else $error("input ready right after a query beat");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(step_count_i) && $stable(saturated_i)))
    else $error("result beat changed while stalled");

endmodule

bind flow_to_step_count_interpolator ftsc_checker u_ftsc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_cmd_i     (in_i.cmd),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .step_count_i (out_o.step_count),
  .saturated_i  (out_o.saturated)
);

`default_nettype wire
